// File: rtl/core/rsh_pkg.sv
// Shared types and constants for the ray/sphere hit test pipeline.
`timescale 1ns / 1ps
`default_nettype none

package rsh_pkg;

	// Ray direction components, signed Q2.12
	localparam int DIR_WIDTH = 14;

	// Configuration register map
	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5,
		REG_RADIUS   = 3'd6
	} cfg_reg_t;

	// Pixel value reported with each result
	localparam int                    BRIGHT_WIDTH = 8;
	localparam logic [BRIGHT_WIDTH-1:0] BRIGHT_HIT   = 8'd255;
	localparam logic [BRIGHT_WIDTH-1:0] BRIGHT_MISS  = 8'd0;

endpackage

`default_nettype wire

// File: rtl/core/rsh_front.sv
// Front pipeline: oc, dot products, c, p squared and the discriminant h = p^2 - c.
`timescale 1ns / 1ps
`default_nettype none

module rsh_front
	import rsh_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 12,
	localparam int OC_WIDTH   = COORD_WIDTH + 1,
	localparam int PD_WIDTH   = OC_WIDTH + DIR_WIDTH,
	localparam int P_WIDTH    = PD_WIDTH + 2,
	localparam int SQ_WIDTH   = 2 * OC_WIDTH,
	localparam int RR_WIDTH   = 2 * (COORD_WIDTH - 1),
	localparam int C_WIDTH    = SQ_WIDTH + 2,
	localparam int CS_WIDTH   = C_WIDTH + 2 * FRAC_BITS,
	localparam int LO_WIDTH   = P_WIDTH / 2,
	localparam int HI_WIDTH   = P_WIDTH - LO_WIDTH,
	localparam int HH_WIDTH   = 2 * HI_WIDTH,
	localparam int LL_WIDTH   = 2 * LO_WIDTH,
	localparam int P2_WIDTH   = 2 * P_WIDTH,
	localparam int HS_WIDTH   = ((P2_WIDTH > CS_WIDTH) ? P2_WIDTH : CS_WIDTH) + 1,
	localparam int H_WIDTH    = HS_WIDTH - 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [DIR_WIDTH-1:0]   dir_x,
	input  logic signed [DIR_WIDTH-1:0]   dir_y,
	input  logic signed [DIR_WIDTH-1:0]   dir_z,
	input  logic signed [COORD_WIDTH-1:0] origin [3],
	input  logic signed [COORD_WIDTH-1:0] center [3],
	input  logic [COORD_WIDTH-2:0]        radius,
	output logic                          out_valid,
	output logic                          out_neg,
	output logic signed [P_WIDTH-1:0]     out_p,
	output logic [H_WIDTH-1:0]            out_h
);

	logic signed [DIR_WIDTH-1:0] d_in [3];
	logic [7:1]                  vld_s;

	logic signed [OC_WIDTH-1:0]  oc_s1 [3];
	logic signed [DIR_WIDTH-1:0] d_s1 [3];
	logic [COORD_WIDTH-2:0]      rad_s1;

	logic signed [PD_WIDTH-1:0]  pd_s2 [3];
	logic signed [SQ_WIDTH-1:0]  sq_s2 [3];
	logic [RR_WIDTH-1:0]         rr_s2;

	logic signed [P_WIDTH-1:0]   p_s3;
	logic signed [C_WIDTH-1:0]   c_s3;

	logic [P_WIDTH-1:0]          pabs_s4;
	logic signed [P_WIDTH-1:0]   p_s4;
	logic signed [CS_WIDTH-1:0]  cs_s4;

	logic [HI_WIDTH-1:0]         pabs_hi;
	logic [LO_WIDTH-1:0]         pabs_lo;
	logic [HH_WIDTH-1:0]         hh_s5;
	logic [P_WIDTH-1:0]          hl_s5;
	logic [LL_WIDTH-1:0]         ll_s5;
	logic signed [P_WIDTH-1:0]   p_s5;
	logic signed [CS_WIDTH-1:0]  cs_s5;

	logic [P2_WIDTH-1:0]         p2_s6;
	logic signed [P_WIDTH-1:0]   p_s6;
	logic signed [CS_WIDTH-1:0]  cs_s6;

	logic signed [HS_WIDTH-1:0]  h_diff;
	logic                        neg_s7;
	logic [H_WIDTH-1:0]          h_s7;
	logic signed [P_WIDTH-1:0]   p_s7;

	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	// Valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:1], in_valid};
		end
	end

	// s1: origin minus center, capture direction
	// s2: per-axis products and r^2
	// s3: p = oc.d, c = oc.oc - r^2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				oc_s1[i] <= OC_WIDTH'(origin[i]) - OC_WIDTH'(center[i]);
				d_s1[i]  <= d_in[i];
				pd_s2[i] <= PD_WIDTH'(oc_s1[i]) * PD_WIDTH'(d_s1[i]);
				sq_s2[i] <= SQ_WIDTH'(oc_s1[i]) * SQ_WIDTH'(oc_s1[i]);
			end
			rad_s1 <= radius;
			rr_s2  <= RR_WIDTH'(rad_s1) * RR_WIDTH'(rad_s1);
			p_s3   <= P_WIDTH'(pd_s2[0]) + P_WIDTH'(pd_s2[1]) + P_WIDTH'(pd_s2[2]);
			c_s3   <= C_WIDTH'(sq_s2[0]) + C_WIDTH'(sq_s2[1]) + C_WIDTH'(sq_s2[2])
				- $signed(C_WIDTH'(rr_s2));
		end
	end

	assign pabs_hi = pabs_s4[P_WIDTH-1:LO_WIDTH];
	assign pabs_lo = pabs_s4[LO_WIDTH-1:0];

	// s4: |p| and c scaled to the p^2 grid
	// s5: |p|^2 as three half-width partial products
	// s6: partial products summed
	always_ff @(posedge clk) begin
		if (en) begin
			pabs_s4 <= p_s3[P_WIDTH-1] ? P_WIDTH'(-p_s3) : P_WIDTH'(p_s3);
			p_s4    <= p_s3;
			cs_s4   <= CS_WIDTH'(c_s3) <<< (2 * FRAC_BITS);

			hh_s5   <= HH_WIDTH'(pabs_hi) * HH_WIDTH'(pabs_hi);
			hl_s5   <= P_WIDTH'(pabs_hi) * P_WIDTH'(pabs_lo);
			ll_s5   <= LL_WIDTH'(pabs_lo) * LL_WIDTH'(pabs_lo);
			p_s5    <= p_s4;
			cs_s5   <= cs_s4;

			p2_s6   <= (P2_WIDTH'(hh_s5) << (2 * LO_WIDTH))
				+ (P2_WIDTH'(hl_s5) << (LO_WIDTH + 1))
				+ P2_WIDTH'(ll_s5);
			p_s6    <= p_s5;
			cs_s6   <= cs_s5;
		end
	end

	// s7: h = p^2 - c, its sign marks a miss
	assign h_diff = HS_WIDTH'($signed({1'b0, p2_s6})) - HS_WIDTH'(cs_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s7 <= h_diff[HS_WIDTH-1];
			h_s7   <= h_diff[H_WIDTH-1:0];
			p_s7   <= p_s6;
		end
	end

	assign out_valid = vld_s[7];
	assign out_neg   = neg_s7;
	assign out_p     = p_s7;
	assign out_h     = h_s7;

endmodule

`default_nettype wire

// File: rtl/core/rsh_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband that rides along.
`timescale 1ns / 1ps
`default_nettype none

module rsh_isqrt #(
	parameter int RAD_WIDTH = 66,
	parameter int SB_WIDTH  = 34,
	localparam int ROOT_WIDTH = RAD_WIDTH / 2,
	localparam int REM_WIDTH  = ROOT_WIDTH + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [RAD_WIDTH-1:0]  in_rad,
	input  logic [SB_WIDTH-1:0]   in_sb,
	output logic                  out_valid,
	output logic [ROOT_WIDTH-1:0] out_root,
	output logic [SB_WIDTH-1:0]   out_sb
);

	logic [REM_WIDTH-1:0]  rem_s  [1:ROOT_WIDTH-1];
	logic [RAD_WIDTH-1:0]  rad_s  [1:ROOT_WIDTH-1];
	logic [ROOT_WIDTH-1:0] root_s [1:ROOT_WIDTH];
	logic [SB_WIDTH-1:0]   sb_s   [1:ROOT_WIDTH];
	logic                  vld_s  [1:ROOT_WIDTH];

	for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
		logic [REM_WIDTH-1:0]  rem_i;
		logic [RAD_WIDTH-1:0]  rad_i;
		logic [ROOT_WIDTH-1:0] root_i;
		logic [SB_WIDTH-1:0]   sb_i;
		logic                  vld_i;
		logic [REM_WIDTH-1:0]  cur;
		logic [REM_WIDTH-1:0]  trial;
		logic                  take;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign rad_i  = in_rad;
			assign root_i = '0;
			assign sb_i   = in_sb;
			assign vld_i  = in_valid;
		end else begin : g_next
			assign rem_i  = rem_s[k];
			assign rad_i  = rad_s[k];
			assign root_i = root_s[k];
			assign sb_i   = sb_s[k];
			assign vld_i  = vld_s[k];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_i[REM_WIDTH-3:0], rad_i[RAD_WIDTH-1 -: 2]};
		assign trial = {root_i, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_i[ROOT_WIDTH-2:0], take};
				sb_s[k+1]   <= sb_i;
			end
		end

		// the last stage keeps no remainder or radicand
		if (k < ROOT_WIDTH - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? (cur - trial) : cur;
					rad_s[k+1] <= {rad_i[RAD_WIDTH-3:0], 2'b00};
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_WIDTH];
	assign out_root  = root_s[ROOT_WIDTH];
	assign out_sb    = sb_s[ROOT_WIDTH];

endmodule

`default_nettype wire

// File: rtl/core/rsh_back.sv
// Back end: both roots of t, root selection, hit decision and Q4.12 saturation.
`timescale 1ns / 1ps
`default_nettype none

module rsh_back #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 12,
	parameter int P_WIDTH     = 33,
	parameter int ROOT_WIDTH  = 33,
	localparam int T0_WIDTH   = ((P_WIDTH > ROOT_WIDTH + 1) ? P_WIDTH : ROOT_WIDTH + 1) + 2,
	localparam int T_WIDTH    = (T0_WIDTH > FRAC_BITS + COORD_WIDTH) ?
		T0_WIDTH : FRAC_BITS + COORD_WIDTH + 1,
	localparam int TQ_WIDTH   = T_WIDTH - FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic                     in_miss,
	input  logic signed [P_WIDTH-1:0] in_p,
	input  logic [ROOT_WIDTH-1:0]    in_root,
	output logic                     out_valid,
	output logic                     out_hit,
	output logic [COORD_WIDTH-1:0]   out_dist
);

	logic signed [T_WIDTH-1:0] p_ext;
	logic signed [T_WIDTH-1:0] s_ext;
	logic                      vld_s1;
	logic                      miss_s1;
	logic signed [T_WIDTH-1:0] tn_s1;
	logic signed [T_WIDTH-1:0] tf_s1;
	logic signed [T_WIDTH-1:0] t_sel;
	logic [TQ_WIDTH-1:0]       tq;
	logic                      over;

	assign p_ext = T_WIDTH'(in_p);
	assign s_ext = $signed(T_WIDTH'(in_root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// near and far root
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s1 <= in_miss;
			tn_s1   <= -p_ext - s_ext;
			tf_s1   <= -p_ext + s_ext;
		end
	end

	// near root unless it lies behind the origin
	assign t_sel   = tn_s1[T_WIDTH-1] ? tf_s1 : tn_s1;
	assign out_hit = !miss_s1 && !t_sel[T_WIDTH-1];
	assign tq      = t_sel[T_WIDTH-1:FRAC_BITS];
	assign over    = |tq[TQ_WIDTH-1:COORD_WIDTH];

	always_comb begin
		if (!out_hit) begin
			out_dist = '0;
		end else if (over) begin
			out_dist = '1;
		end else begin
			out_dist = tq[COORD_WIDTH-1:0];
		end
	end

	assign out_valid = vld_s1;

endmodule

`default_nettype wire

// File: rtl/core/ray_sphere_hit_test.sv
// Top level of the ray/sphere hit test: configuration registers, pipeline and output buffer.
`timescale 1ns / 1ps
`default_nettype none

// Ray/sphere hit test. Each beat on the ray channel carries one ray direction
// (signed Q2.12, taken as unit length); the ray origin, sphere center and radius
// come from configuration registers 0..6, which must only be written while no
// ray is in flight. Each ray yields exactly one result beat, in order: hit,
// hit_distance (unsigned Q4.12, floored, saturated, 0 on a miss) and
// brightness (255 on a hit, 0 on a miss). The block takes one ray per clock
// while ray_ready is high. Between an accepted ray and its result on res_valid
// lie 7 front stages, one square root stage per root bit (RAD/2 of them, where
// RAD is the discriminant width rounded up to even, so 33 at the default
// widths), one root-select stage and the output register. A two-entry output
// buffer decouples the sides, so rays keep flowing while one result waits;
// ray_ready drops only once both entries are full.
module ray_sphere_hit_test
	import rsh_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          ray_valid,
	output logic                          ray_ready,
	input  logic signed [DIR_WIDTH-1:0]   dir_x,
	input  logic signed [DIR_WIDTH-1:0]   dir_y,
	input  logic signed [DIR_WIDTH-1:0]   dir_z,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          hit,
	output logic [COORD_WIDTH-1:0]        hit_distance,
	output logic [BRIGHT_WIDTH-1:0]       brightness
);

	localparam int OC_WIDTH   = COORD_WIDTH + 1;
	localparam int P_WIDTH    = OC_WIDTH + DIR_WIDTH + 2;
	localparam int C_WIDTH    = 2 * OC_WIDTH + 2;
	localparam int CS_WIDTH   = C_WIDTH + 2 * FRAC_BITS;
	localparam int P2_WIDTH   = 2 * P_WIDTH;
	localparam int HS_WIDTH   = ((P2_WIDTH > CS_WIDTH) ? P2_WIDTH : CS_WIDTH) + 1;
	localparam int H_WIDTH    = HS_WIDTH - 1;
	localparam int RAD_WIDTH  = H_WIDTH + (H_WIDTH % 2);
	localparam int ROOT_WIDTH = RAD_WIDTH / 2;

	localparam logic signed [COORD_WIDTH-1:0] CENTER_Z_RESET =
		COORD_WIDTH'(-(64'sd1 <<< FRAC_BITS));
	localparam logic [COORD_WIDTH-2:0] RADIUS_RESET =
		(COORD_WIDTH - 1)'(64'd1 << (FRAC_BITS - 1));

	logic signed [COORD_WIDTH-1:0] origin_q [3];
	logic signed [COORD_WIDTH-1:0] center_q [3];
	logic [COORD_WIDTH-2:0]        radius_q;

	logic                      en;
	logic                      f_valid;
	logic                      f_neg;
	logic signed [P_WIDTH-1:0] f_p;
	logic [H_WIDTH-1:0]        f_h;
	logic                      s_valid;
	logic [ROOT_WIDTH-1:0]     s_root;
	logic [P_WIDTH:0]          s_sb;
	logic                      b_valid;
	logic                      b_hit;
	logic [COORD_WIDTH-1:0]    b_dist;

	logic                      out_valid_q;
	logic                      out_hit_q;
	logic [COORD_WIDTH-1:0]    out_dist_q;
	logic                      skid_valid_q;
	logic                      skid_hit_q;
	logic [COORD_WIDTH-1:0]    skid_dist_q;
	logic                      push;
	logic                      pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= CENTER_Z_RESET;
			radius_q    <= RADIUS_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X: origin_q[0] <= cfg_data;
				REG_ORIGIN_Y: origin_q[1] <= cfg_data;
				REG_ORIGIN_Z: origin_q[2] <= cfg_data;
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_RADIUS:   radius_q    <= cfg_data[COORD_WIDTH-2:0];
				default: ;
			endcase
		end
	end

	// Whole pipeline advances unless the output skid entry is occupied
	assign en        = !skid_valid_q;
	assign ray_ready = en;

	rsh_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ray_valid),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.origin    (origin_q),
		.center    (center_q),
		.radius    (radius_q),
		.out_valid (f_valid),
		.out_neg   (f_neg),
		.out_p     (f_p),
		.out_h     (f_h)
	);

	rsh_isqrt #(
		.RAD_WIDTH (RAD_WIDTH),
		.SB_WIDTH  (P_WIDTH + 1)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_rad    (RAD_WIDTH'(f_h)),
		.in_sb     ({f_neg, f_p}),
		.out_valid (s_valid),
		.out_root  (s_root),
		.out_sb    (s_sb)
	);

	rsh_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.P_WIDTH     (P_WIDTH),
		.ROOT_WIDTH  (ROOT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_valid),
		.in_miss   (s_sb[P_WIDTH]),
		.in_p      ($signed(s_sb[P_WIDTH-1:0])),
		.in_root   (s_root),
		.out_valid (b_valid),
		.out_hit   (b_hit),
		.out_dist  (b_dist)
	);

	// Output register plus one skid entry
	assign push = en && b_valid;
	assign pop  = out_valid_q && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_hit_q  <= skid_hit_q;
				out_dist_q <= skid_dist_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_hit_q  <= b_hit;
				skid_dist_q <= b_dist;
			end else begin
				out_hit_q  <= b_hit;
				out_dist_q <= b_dist;
			end
		end
	end

	assign res_valid    = out_valid_q;
	assign hit          = out_hit_q;
	assign hit_distance = out_dist_q;
	assign brightness   = out_hit_q ? BRIGHT_HIT : BRIGHT_MISS;

`ifndef NO_ASSERTIONS
	// skid entry is only ever behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid)
		else $error("skid entry valid while output register empty");

	// skid fills only after the output was stalled
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(res_valid && !res_ready))
		else $error("skid entry filled without an output stall");

	// a miss carries zero distance
	a_miss_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !hit) |-> (hit_distance == '0))
		else $error("miss beat with nonzero hit_distance");
`endif

endmodule

`default_nettype wire
